// ----- hdl/nmss_pkg.sv -----
// ----------------------------------------------------------------------------
// nmss_pkg
// Shared types and constants for the neighbour mask sprite select block.
// ----------------------------------------------------------------------------
package nmss_pkg;

  // Default sizing
  localparam int MAX_RULES_DEF = 128;
  localparam int ID_BITS_DEF   = 8;

  // Fixed field widths
  localparam int XY_W      = 12;
  localparam int MASK_W    = 8;
  localparam int NBR_N     = 8;
  localparam int NBR_ID_W  = 8;
  localparam int REQ_W     = 2;
  localparam int CFG_IDX_W = 8;

  // Stream widths, whole bytes
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 32;

  // Request kinds carried in tuser
  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 2'd0,
    REQ_CLEAR  = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_Y = 8'd1;

  // One stored rule, expected mask in the low bits
  typedef struct packed {
    logic [XY_W-1:0]   y;
    logic [XY_W-1:0]   x;
    logic [MASK_W-1:0] ignore;
    logic [MASK_W-1:0] expected;
  } rule_t;

  localparam int RULE_W = $bits(rule_t);

  // One result, box_x in the low bits
  typedef struct packed {
    logic            rule_accepted;
    logic            used_default;
    logic            box_changed;
    logic [XY_W-1:0] box_y;
    logic [XY_W-1:0] box_x;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

// ----- hdl/neighbour_mask_sprite_select.sv -----
// Append, clear and unknown requests are written straight into a pending result;
// a tileset lookup on a filled table first reads the rules in order until the
// first match or the end of the table. The pending result then moves into the
// output register as soon as that is free. One request is in work at a time:
// the next is taken only after the result has moved on, so a waiting result holds it back.
// Reset empties the table (count to zero) and clears the default position.
// ----------------------------------------------------------------------------
// neighbour_mask_sprite_select
// Ordered autotile rule table with first-match lookup on a same-id mask.
// ----------------------------------------------------------------------------
module neighbour_mask_sprite_select
  import nmss_pkg::*;
#(
  parameter int MAX_RULES = MAX_RULES_DEF,
  parameter int ID_BITS   = ID_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // Request stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // tdata from bit 0: expected_mask[8], ignore_mask[8], rule_sprite_x[12],
  // rule_sprite_y[12], tiled[1], self_id[8], neighbour_ids[64], zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // tuser: req_type[2]
  input  logic [REQ_W-1:0]       s_tuser,
  // Result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // tdata from bit 0: box_x[12], box_y[12], box_changed[1], used_default[1],
  // rule_accepted[1], zero pad
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // Configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [XY_W-1:0]        cfg_data
);

  localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CW = $clog2(MAX_RULES + 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_RULES);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_PUSH = 3'b100
  } state_t;

  state_t            state;
  logic [CW-1:0]     rule_count;
  logic [AW-1:0]     chk;
  logic [MASK_W-1:0] same;
  logic [MASK_W-1:0] same_next;
  logic [XY_W-1:0]   default_x;
  logic [XY_W-1:0]   default_y;
  result_t           pend;
  result_t           out_res;

  // Request field views
  req_t                  req;
  rule_t                 in_rule;
  logic                  tiled;
  logic [NBR_ID_W-1:0]   self_id;
  logic [NBR_N*NBR_ID_W-1:0] neighbour_ids;

  assign req           = req_t'(s_tuser);
  assign in_rule       = rule_t'(s_tdata[RULE_W-1:0]);
  assign tiled         = s_tdata[40];
  assign self_id       = s_tdata[48:41];
  assign neighbour_ids = s_tdata[112:49];

  logic s_fire;
  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;

  // Configuration is always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_x <= '0;
      default_y <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_DEFAULT_X) begin
        default_x <= cfg_data;
      end else if (cfg_index == CFG_DEFAULT_Y) begin
        default_y <= cfg_data;
      end
    end
  end

  // Build the same-id mask, comparing the low ID_BITS of each id
  always_comb begin
    for (int i = 0; i < NBR_N; i++) begin
      same_next[i] = (neighbour_ids[i*NBR_ID_W +: ID_BITS] == self_id[ID_BITS-1:0]);
    end
  end

  // Rule table
  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  rule_t         ram_rdata;
  logic          table_full;

  assign table_full = (rule_count == COUNT_FULL);
  assign ram_we     = s_fire && (req == REQ_APPEND) && !table_full;
  assign ram_re     = s_fire || (state == ST_SCAN);
  assign ram_raddr  = (state == ST_SCAN) ? AW'(chk + AW'(1)) : '0;

  nmss_ram #(
    .WIDTH (RULE_W),
    .DEPTH (MAX_RULES),
    .AW    (AW)
  ) u_rule_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rule_count[AW-1:0]),
    .wdata (in_rule),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Compare the entry read this cycle against the mask
  logic scan_hit;
  logic scan_last;
  assign scan_hit  = (((ram_rdata.expected ^ same) & ~ram_rdata.ignore) == '0);
  assign scan_last = ((CW'(chk) + CW'(1)) == rule_count);

  result_t default_res;
  result_t hit_res;
  result_t accept_res;
  always_comb begin
    default_res              = '0;
    default_res.box_x        = default_x;
    default_res.box_y        = default_y;
    default_res.box_changed  = 1'b1;
    default_res.used_default = 1'b1;
  end

  always_comb begin
    hit_res             = '0;
    hit_res.box_x       = ram_rdata.x;
    hit_res.box_y       = ram_rdata.y;
    hit_res.box_changed = 1'b1;
  end

  always_comb begin
    accept_res               = '0;
    accept_res.rule_accepted = 1'b1;
  end

  // Sequencer: take a request, scan if needed, then hand the result over
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rule_count <= '0;
      chk        <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_fire) begin
            same <= same_next;
            chk  <= '0;
            unique case (req)
              REQ_APPEND: begin
                state <= ST_PUSH;
                if (!table_full) begin
                  rule_count <= rule_count + CW'(1);
                  pend       <= accept_res;
                end else begin
                  pend <= '0;
                end
              end
              REQ_CLEAR: begin
                rule_count <= '0;
                pend       <= '0;
                state      <= ST_PUSH;
              end
              REQ_LOOKUP: begin
                if (tiled && (rule_count == '0)) begin
                  pend  <= default_res;
                  state <= ST_PUSH;
                end else if (tiled) begin
                  pend  <= '0;
                  state <= ST_SCAN;
                end else begin
                  pend  <= '0;
                  state <= ST_PUSH;
                end
              end
              REQ_NONE: begin
                pend  <= '0;
                state <= ST_PUSH;
              end
              default: begin
                pend  <= '0;
                state <= ST_PUSH;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_hit) begin
            pend  <= hit_res;
            state <= ST_PUSH;
          end else if (scan_last) begin
            pend  <= default_res;
            state <= ST_PUSH;
          end else begin
            chk <= chk + AW'(1);
          end
        end
        ST_PUSH: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register, refilled as soon as the previous result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_PUSH) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_PUSH) && (!m_tvalid || m_tready)) begin
      out_res <= pend;
    end
  end

  assign m_tdata = {(OUT_TDATA_W - RESULT_W)'(0), out_res};

endmodule

// ----- hdl/nmss_ram.sv -----
// ----------------------------------------------------------------------------
// nmss_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module nmss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- tb/sv/neighbour_mask_sprite_select_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbour_mask_sprite_select_test
// Self-checking bench for the autotile rule table and first-match lookup.
// Requests come from a queue that the stimulus process fills in phases. A
// clocked driver offers them on the request stream and runs a model of the
// rule table on every accepted request. A clocked monitor compares every
// result field by field with the oldest predicted box. The default position
// registers are rewritten between phases, once the block has drained.
// ----------------------------------------------------------------------------
module neighbour_mask_sprite_select_test;
  import nmss_pkg::*;

  localparam int IDLE_PCT   = 26;
  localparam int HOLD_AT    = 500;
  localparam int HOLD_LEN   = 600;
  localparam int PHASE_REQS = 180;

  // One request, as the stimulus sees it
  typedef struct {
    req_t             kind;
    logic [MASK_W-1:0] exp_mask;
    logic [MASK_W-1:0] ign_mask;
    logic [XY_W-1:0]   sx;
    logic [XY_W-1:0]   sy;
    logic              tileset;
    logic [7:0]        self_id;
    logic [63:0]       nbrs;
  } tile_req_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [REQ_W-1:0]       s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [XY_W-1:0]        cfg_data = '0;

  // Stimulus and checking state
  tile_req_t pending_requests[$];
  result_t   expected_boxes[$];
  rule_t     aim_rules[$];
  tile_req_t offered;
  bit        steady = 1'b0;
  bit        hold_done = 1'b0;
  int        hold_left = 0;
  int        fails = 0;
  int        results_seen = 0;
  int        n_accepted = 0;

  // Model of the rule table
  rule_t           model_rules[MAX_RULES_DEF];
  int              model_count = 0;
  logic [XY_W-1:0] model_dflt_x = '0;
  logic [XY_W-1:0] model_dflt_y = '0;
  int              n_lookups = 0;
  int              n_matched = 0;
  int              n_default = 0;
  int              n_refused = 0;

  neighbour_mask_sprite_select uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Advance the rule table model by one request and return the box it gives
  function automatic result_t predict_box(input tile_req_t rq);
    result_t           r;
    logic [MASK_W-1:0] same;
    logic [MASK_W-1:0] diff;
    bit                hit;
    r = '0;
    hit = 1'b0;
    case (rq.kind)
      REQ_APPEND: begin
        if (model_count < MAX_RULES_DEF) begin
          model_rules[model_count] = '{y: rq.sy, x: rq.sx, ignore: rq.ign_mask,
                                       expected: rq.exp_mask};
          model_count++;
          r.rule_accepted = 1'b1;
        end else begin
          n_refused++;
        end
      end
      REQ_CLEAR: model_count = 0;
      REQ_LOOKUP: begin
        if (rq.tileset) begin
          n_lookups++;
          for (int i = 0; i < NBR_N; i++)
            same[i] = (rq.nbrs[8*i +: 8] == rq.self_id);
          for (int k = 0; k < model_count && !hit; k++) begin
            diff = (model_rules[k].expected ^ same) & ~model_rules[k].ignore;
            if (diff == '0) begin
              hit = 1'b1;
              r.box_x = model_rules[k].x;
              r.box_y = model_rules[k].y;
            end
          end
          if (hit) begin
            n_matched++;
          end else begin
            n_default++;
            r.box_x = model_dflt_x;
            r.box_y = model_dflt_y;
            r.used_default = 1'b1;
          end
          r.box_changed = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Request with every field random, then of the given kind
  function automatic tile_req_t noise_req(input req_t kind);
    tile_req_t rq;
    rq.kind     = kind;
    rq.exp_mask = 8'($urandom);
    rq.ign_mask = 8'($urandom);
    rq.sx       = 12'($urandom);
    rq.sy       = 12'($urandom);
    rq.tileset  = 1'($urandom);
    rq.self_id  = 8'($urandom);
    rq.nbrs     = {$urandom, $urandom};
    return rq;
  endfunction

  task automatic add_rule(input logic [7:0] e, input logic [7:0] ig,
                          input logic [11:0] x, input logic [11:0] y);
    tile_req_t rq;
    rq = noise_req(REQ_APPEND);
    rq.exp_mask = e;
    rq.ign_mask = ig;
    rq.sx = x;
    rq.sy = y;
    pending_requests.push_back(rq);
    if (aim_rules.size() < MAX_RULES_DEF)
      aim_rules.push_back('{y: y, x: x, ignore: ig, expected: e});
  endtask

  // Lookup whose neighbours give exactly the wanted same-id mask
  task automatic add_lookup(input logic [7:0] mask, input logic ts, input logic [7:0] self);
    tile_req_t rq;
    rq = noise_req(REQ_LOOKUP);
    rq.tileset = ts;
    rq.self_id = self;
    for (int i = 0; i < NBR_N; i++)
      rq.nbrs[8*i +: 8] = mask[i] ? self : self ^ 8'($urandom_range(1, 255));
    pending_requests.push_back(rq);
  endtask

  task automatic add_clear();
    pending_requests.push_back(noise_req(REQ_CLEAR));
    aim_rules.delete();
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [XY_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_DEFAULT_X)
      model_dflt_x = val;
    else if (idx == CFG_DEFAULT_Y)
      model_dflt_y = val;
  endtask

  // Hold until every request is taken and every result has come back;
  // sample between edges so the driver's updates have settled
  task automatic drain();
    @(negedge clk);
    while (pending_requests.size() != 0 || s_tvalid || expected_boxes.size() != 0)
      @(negedge clk);
    repeat (MAX_RULES_DEF + 4) @(posedge clk);
  endtask

  // Request driver: offer the next pending request, predict on acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_boxes.push_back(predict_box(offered));
        n_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_requests.size() != 0 &&
            (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          offered = pending_requests.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= offered.kind;
          s_tdata  <= {7'b0, offered.nbrs, offered.self_id, offered.tileset,
                       offered.sy, offered.sx, offered.ign_mask, offered.exp_mask};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fails++;
    end
  endfunction

  // Result monitor: compare with the oldest prediction, stall at random
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[RESULT_W-1:0];
        results_seen++;
        if (expected_boxes.size() == 0) begin
          $error("result with nothing expected: tdata %h", m_tdata);
          fails++;
        end else begin
          want = expected_boxes.pop_front();
          check_field("box_x", int'(want.box_x), int'(got.box_x));
          check_field("box_y", int'(want.box_y), int'(got.box_y));
          check_field("box_changed", int'(want.box_changed), int'(got.box_changed));
          check_field("used_default", int'(want.used_default), int'(got.used_default));
          check_field("rule_accepted", int'(want.rule_accepted),
                      int'(got.rule_accepted));
        end
      end
      // Long hold-off once, so the block backs up into the request side
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= steady || $urandom_range(0, 99) >= IDLE_PCT;
      end
    end
  end

  // Stimulus: directed requests, then random phases with new defaults
  initial begin
    int        n_rules;
    int        roll;
    int        k;
    logic [7:0] mask;
    rule_t     ar;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    write_reg(CFG_DEFAULT_X, 12'hFFF);
    write_reg(CFG_DEFAULT_Y, 12'hFFF);

    // Empty table, no tileset, unknown request type
    add_lookup(8'hFF, 1'b1, 8'h00);
    add_lookup(8'h00, 1'b0, 8'hFF);
    pending_requests.push_back(noise_req(REQ_NONE));
    // All same, none same, everything ignored
    add_rule(8'hFF, 8'h00, 12'h000, 12'hFFF);
    add_rule(8'h00, 8'h00, 12'hFFF, 12'h000);
    add_rule(8'hA5, 8'hFF, 12'd123, 12'd456);
    add_lookup(8'hFF, 1'b1, 8'hFF);
    add_lookup(8'h00, 1'b1, 8'h00);
    add_lookup(8'h5A, 1'b1, 8'h80);
    add_lookup(8'h5A, 1'b0, 8'h01);
    // Clear, then miss on an empty table
    add_clear();
    add_lookup(8'hFF, 1'b1, 8'h7F);
    // Partial ignore: hit and miss
    add_rule(8'h0F, 8'hF0, 12'd77, 12'd99);
    add_lookup(8'h3F, 1'b1, 8'hFE);
    add_lookup(8'h0E, 1'b1, 8'h55);
    pending_requests.push_back(noise_req(REQ_NONE));
    add_clear();
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        1: begin
          write_reg(CFG_DEFAULT_X, 12'h000);
          write_reg(CFG_DEFAULT_Y, 12'h000);
        end
        5: begin
          write_reg(CFG_DEFAULT_X, 12'hFFF);
          write_reg(CFG_DEFAULT_Y, 12'h000);
        end
        default: begin
          write_reg(CFG_DEFAULT_X, 12'($urandom));
          write_reg(CFG_DEFAULT_Y, 12'($urandom));
        end
      endcase
      steady = (p == 3);
      if ($urandom_range(0, 9) != 0 || p == 2)
        add_clear();
      // One phase overfills the table so appends get refused
      n_rules = (p == 2) ? MAX_RULES_DEF + 8 : $urandom_range(1, 24);
      for (int i = 0; i < n_rules; i++)
        add_rule(8'($urandom), 8'($urandom & $urandom), 12'($urandom), 12'($urandom));
      for (int i = 0; i < PHASE_REQS; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          // Aim at a stored rule, with its ignored bits random
          mask = 8'($urandom);
          if (aim_rules.size() != 0) begin
            k = $urandom_range(0, aim_rules.size() - 1);
            ar = aim_rules[k];
            mask = (ar.expected & ~ar.ignore) | (mask & ar.ignore);
          end
          add_lookup(mask, $urandom_range(0, 9) != 0, 8'($urandom));
        end else if (roll < 80) begin
          add_rule(8'($urandom), 8'($urandom & $urandom), 12'($urandom), 12'($urandom));
        end else if (roll < 82) begin
          add_clear();
        end else if (roll < 88) begin
          pending_requests.push_back(noise_req(REQ_NONE));
        end else begin
          add_lookup(8'($urandom), 1'b1, 8'($urandom));
        end
      end
      drain();
    end

    steady = 1'b0;
    $display("Ran %0d requests: %0d tileset lookups, %0d hit a rule, %0d took the default,",
             n_accepted, n_lookups, n_matched, n_default);
    $display("%0d appends refused on a full table, six sets of default positions.", n_refused);
    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit
  initial begin
    #18_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
